// ===== hdl/lfsg_pkg.sv =====
// Package for the LCD frame scan with ghosting levels.
// Holds the frame geometry, level constants, item and register codes and shared types.
// No dependencies.
package lfsg_pkg;

   // Frame geometry: 48x32 pixels, 6 bytes of 8 pixels per row
   localparam int unsigned FRAME_ROWS  = 32;
   localparam int unsigned ROW_BYTES   = 6;
   localparam int unsigned STORE_DEPTH = FRAME_ROWS * ROW_BYTES;
   localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
   localparam int unsigned PIX         = 8;
   localparam int unsigned LVL_W       = 4;

   // Top level of the persistence scale (levels run 0..8)
   localparam int unsigned GHOST_LEVELS = 8;

   // Scroll start decode and address walk constants
   localparam logic [7:0] START_BIAS  = 8'h83;
   localparam logic [3:0] SKIP_AT     = 4'd12;
   localparam logic [7:0] SKIP_LEN    = 8'd4;
   localparam logic [7:0] BANK_SPAN   = 8'd128;
   localparam logic [1:0] LAST_BANK   = 2'd2;
   localparam logic [7:0] LAST_BANK_W = 8'd6;

   typedef logic [LVL_W-1:0] level_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_DATA  = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_SCROLL_START = 1'b0,
      CSR_GHOSTING_ON  = 1'b1
   } csr_index_type;

   // Fetch address and scan position
   typedef struct packed {
      logic [1:0] bank;
      logic [6:0] offset;
      logic [4:0] row;
      logic [2:0] col;
   } scan_type;

endpackage

// ===== hdl/lfsg_if.sv =====
// Handshake channel interfaces for the frame scan block.
// Request carries one item in, response carries one result out. Uses lfsg_pkg.
interface lfsg_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] display_byte;

   modport source (output valid, output kind, output display_byte, input ready);
   modport sink   (input valid, input kind, input display_byte, output ready);
endinterface

interface lfsg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_levels;
   logic [4:0]  row;
   logic [2:0]  byte_column;
   logic        changed;
   logic [1:0]  next_bank;
   logic [6:0]  next_offset;
   logic        frame_last;

   modport source (output valid, output pixel_levels, output row, output byte_column,
                   output changed, output next_bank, output next_offset,
                   output frame_last, input ready);
   modport sink   (input valid, input pixel_levels, input row, input byte_column,
                   input changed, input next_bank, input next_offset,
                   input frame_last, output ready);
endinterface

// ===== hdl/lfsg_walk.sv =====
// Fetch address walk and scan position step for the frame scan block.
// Derives the start address, the next address, the store index and the last-byte flag.
// Uses lfsg_pkg.
module lfsg_walk (
   input  logic [7:0]                     scroll_start,
   input  lfsg_pkg::scan_type             cur,
   output lfsg_pkg::scan_type             start_pos,
   output lfsg_pkg::scan_type             next_pos,
   output logic [lfsg_pkg::IDX_W-1:0]     store_idx,
   output logic                           last
);

   logic [7:0] start_v;
   logic [7:0] off_w;
   logic [2:0] bank_w;
   logic [2:0] col_eff;
   logic [2:0] col_nx;
   logic [4:0] row_nx;

   // Start address from the scroll register
   always_comb begin
      start_v = (scroll_start >= lfsg_pkg::START_BIAS) ?
                scroll_start - lfsg_pkg::START_BIAS : scroll_start;
      start_pos.bank   = start_v[7:6];
      start_pos.offset = {start_v[5:0], 1'b0};
      start_pos.row    = '0;
      start_pos.col    = '0;
   end

   // Address step: skip the gap in each 16, roll into next bank, wrap bank 2
   always_comb begin
      off_w  = {1'b0, cur.offset} + 8'd1;
      bank_w = {1'b0, cur.bank};
      if (off_w[3:0] >= lfsg_pkg::SKIP_AT) begin
         off_w = off_w + lfsg_pkg::SKIP_LEN;
      end
      if (off_w >= lfsg_pkg::BANK_SPAN) begin
         off_w  = off_w - lfsg_pkg::BANK_SPAN;
         bank_w = bank_w + 3'd1;
      end
      if (bank_w == {1'b0, lfsg_pkg::LAST_BANK} && off_w >= lfsg_pkg::LAST_BANK_W) begin
         off_w  = off_w - lfsg_pkg::LAST_BANK_W;
         bank_w = '0;
      end
   end

   // Scan position step and store index
   always_comb begin
      col_eff = (cur.col >= 3'(lfsg_pkg::ROW_BYTES)) ? 3'd0 : cur.col;
      if (col_eff == 3'(lfsg_pkg::ROW_BYTES - 1)) begin
         col_nx = '0;
         row_nx = cur.row + 5'd1;
      end else begin
         col_nx = col_eff + 3'd1;
         row_nx = cur.row;
      end
      // row * 6 as row*4 + row*2
      store_idx = lfsg_pkg::IDX_W'({cur.row, 2'b00}) + lfsg_pkg::IDX_W'({cur.row, 1'b0})
                + lfsg_pkg::IDX_W'(col_eff);
      last = (cur.row == 5'(lfsg_pkg::FRAME_ROWS - 1)) &&
             (col_eff == 3'(lfsg_pkg::ROW_BYTES - 1));
   end

   // Next position in struct order: bank, offset, row, column
   assign next_pos = {bank_w[1:0], off_w[6:0], row_nx, col_nx};

endmodule

// ===== hdl/lfsg_lane.sv =====
// One pixel lane: saturating level update for a single pixel.
// Eight of these run side by side on one byte. Uses lfsg_pkg.
module lfsg_lane (
   input  lfsg_pkg::level_type prev,
   input  logic                unset,
   input  logic                pixel,
   input  logic                ghost_on,
   output lfsg_pkg::level_type level,
   output logic                changed
);

   localparam logic [4:0] TOP = 5'(lfsg_pkg::GHOST_LEVELS);

   lfsg_pkg::level_type base;
   lfsg_pkg::level_type step;
   logic [4:0]          sum;

   always_comb begin
      // unset pixel counts as level zero
      base = unset ? '0 : prev;
      step = ghost_on ? 4'd1 : TOP[3:0];
      sum  = {1'b0, base} + {1'b0, step};
      if (pixel) begin
         level = (sum > TOP) ? TOP[3:0] : sum[3:0];
      end else begin
         level = (base < step) ? '0 : base - step;
      end
      changed = unset || (level != base);
   end

endmodule

// ===== hdl/lfsg_merge.sv =====
// Merge stage: packs the lane levels into the result word and ORs the change flags.
// Start items report a zero word and no change. Uses lfsg_pkg.
module lfsg_merge (
   input  lfsg_pkg::level_type [lfsg_pkg::PIX-1:0] lane_level,
   input  logic [lfsg_pkg::PIX-1:0]                lane_changed,
   input  logic                                    is_data,
   output logic [lfsg_pkg::PIX*lfsg_pkg::LVL_W-1:0] word,
   output logic                                    changed
);

   always_comb begin
      word    = '0;
      changed = 1'b0;
      if (is_data) begin
         // lane i sits in nibble i, so the leftmost pixel lands on top
         for (int i = 0; i < lfsg_pkg::PIX; i++) begin
            word[i*lfsg_pkg::LVL_W +: lfsg_pkg::LVL_W] = lane_level[i];
         end
         changed = |lane_changed;
      end
   end

endmodule

// ===== hdl/lcd_frame_scan_ghosting.sv =====
// LCD frame scan with per-pixel ghosting levels: top level.
// Pipeline: 2 register stages (store read, then update); an accepted item moves from the
// store read stage into the output register only when the output is free or being taken.
// Throughput: one item per cycle while the receiver keeps up; the store's one read and
// one write per cycle and the write-back forward set it.
// Reset (synchronous): scan position, fetch address and registers go to zero, the output
// empties, and the 192 store entry valid bits clear at once, so every pixel reads as unset.
// Depends on lfsg_pkg, lfsg_if, lfsg_walk, lfsg_lane and lfsg_merge.
module lcd_frame_scan_ghosting (
   input  logic         clock,
   input  logic         reset,
   lfsg_req_if.sink     req_ch,
   lfsg_rsp_if.source   rsp_ch,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);

   localparam int unsigned IDX_W = lfsg_pkg::IDX_W;
   localparam int unsigned DEPTH = lfsg_pkg::STORE_DEPTH;
   localparam int unsigned PIX   = lfsg_pkg::PIX;
   localparam int unsigned WORD_W = PIX * lfsg_pkg::LVL_W;

   // Configuration registers
   logic [7:0] scroll_ff;
   logic       ghost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_ff <= '0;
         ghost_ff  <= 1'b0;
      end else if (csr_we) begin
         case (lfsg_pkg::csr_index_type'(csr_index))
            lfsg_pkg::CSR_SCROLL_START: scroll_ff <= csr_wdata;
            lfsg_pkg::CSR_GHOSTING_ON:  ghost_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic req_acc;
   logic req_data;
   logic mem_we;

   logic                s1_data_ff;
   logic [7:0]          s1_byte_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [4:0]          s1_row_ff;
   logic [2:0]          s1_col_ff;
   logic                s1_last_ff;
   logic [1:0]          s1_bank_ff;
   logic [6:0]          s1_off_ff;
   logic                s1_ghost_ff;
   logic                s1_set_ff, s1_set_in;
   logic                s1_fwd_ff, s1_fwd_in;
   logic [WORD_W-1:0]   s1_fwd_word_ff;
   logic [WORD_W-1:0]   mem_rd_ff;

   lfsg_pkg::scan_type  scan_ff, scan_in;
   lfsg_pkg::scan_type  start_pos, next_pos;
   logic [IDX_W-1:0]    rd_idx;
   logic                rd_last;

   logic [DEPTH-1:0]    valid_ff;
   logic [WORD_W-1:0]   level_mem [DEPTH];

   logic [WORD_W-1:0]   prev_word;
   logic [WORD_W-1:0]   new_word;
   logic                new_changed;
   lfsg_pkg::level_type [PIX-1:0] lane_level;
   logic [PIX-1:0]      lane_changed;

   assign advance  = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_acc  = req_ch.valid && req_ch.ready;
   assign req_data = lfsg_pkg::kind_type'(req_ch.kind) == lfsg_pkg::KIND_DATA;
   assign mem_we   = s1_valid_ff && advance && s1_data_ff;

   // Address walk and scan position
   lfsg_walk u_walk (
      .scroll_start (scroll_ff),
      .cur          (scan_ff),
      .start_pos    (start_pos),
      .next_pos     (next_pos),
      .store_idx    (rd_idx),
      .last         (rd_last)
   );

   always_comb begin
      scan_in = scan_ff;
      if (req_acc) begin
         scan_in = req_data ? next_pos : start_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in;
      end
   end

   // Forward the word being written back when the same entry is read in that cycle
   always_comb begin
      s1_fwd_in = mem_we && (s1_idx_ff == rd_idx);
      s1_set_in = s1_fwd_in || valid_ff[rd_idx];
   end

   // Stage 1: accepted item and its store read
   assign s1_valid_in = req_acc || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_data_ff     <= req_data;
         s1_byte_ff     <= req_ch.display_byte;
         s1_idx_ff      <= rd_idx;
         s1_row_ff      <= req_data ? scan_ff.row : 5'd0;
         s1_col_ff      <= req_data ? scan_ff.col : 3'd0;
         s1_last_ff     <= req_data && rd_last;
         s1_bank_ff     <= req_data ? next_pos.bank : start_pos.bank;
         s1_off_ff      <= req_data ? next_pos.offset : start_pos.offset;
         s1_ghost_ff    <= ghost_ff;
         s1_set_ff      <= s1_set_in;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_word_ff <= new_word;
      end
   end

   // Level store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         level_mem[s1_idx_ff] <= new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         mem_rd_ff <= level_mem[rd_idx];
      end
   end

   // Entry valid bits: a clear bit reads as level zero with every pixel unset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[s1_idx_ff] <= 1'b1;
      end
   end

   assign prev_word = s1_fwd_ff ? s1_fwd_word_ff : mem_rd_ff;

   // Pixel lanes
   for (genvar g = 0; g < PIX; g++) begin : g_lane
      lfsg_lane u_lane (
         .prev     (prev_word[g*lfsg_pkg::LVL_W +: lfsg_pkg::LVL_W]),
         .unset    (!s1_set_ff),
         .pixel    (s1_byte_ff[g]),
         .ghost_on (s1_ghost_ff),
         .level    (lane_level[g]),
         .changed  (lane_changed[g])
      );
   end

   lfsg_merge u_merge (
      .lane_level   (lane_level),
      .lane_changed (lane_changed),
      .is_data      (s1_data_ff),
      .word         (new_word),
      .changed      (new_changed)
   );

   // Output register
   assign out_valid_in = s1_valid_ff || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   logic [WORD_W-1:0] out_word_ff;
   logic [4:0]        out_row_ff;
   logic [2:0]        out_col_ff;
   logic              out_changed_ff;
   logic [1:0]        out_bank_ff;
   logic [6:0]        out_off_ff;
   logic              out_last_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         out_word_ff    <= new_word;
         out_row_ff     <= s1_row_ff;
         out_col_ff     <= s1_col_ff;
         out_changed_ff <= new_changed;
         out_bank_ff    <= s1_bank_ff;
         out_off_ff     <= s1_off_ff;
         out_last_ff    <= s1_last_ff;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.pixel_levels = out_word_ff;
   assign rsp_ch.row          = out_row_ff;
   assign rsp_ch.byte_column  = out_col_ff;
   assign rsp_ch.changed      = out_changed_ff;
   assign rsp_ch.next_bank    = out_bank_ff;
   assign rsp_ch.next_offset  = out_off_ff;
   assign rsp_ch.frame_last   = out_last_ff;

endmodule

// ===== bench/lfsg_checker.sv =====
// Scoreboard for the LCD frame scan block: predicts each result from the items and
// register writes it watches, then compares the response channel field by field.
// Depends on lfsg_pkg and lfsg_if.
module lfsg_checker
   import lfsg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lfsg_req_if        req_mon,
   lfsg_rsp_if        rsp_mon,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatches,
   output int         outstanding
);

   typedef struct packed {
      logic [31:0] levels;
      logic [4:0]  row;
      logic [2:0]  col;
      logic        changed;
      logic [1:0]  bank;
      logic [6:0]  offset;
      logic        last;
   } scan_result_type;

   // Shadow of the block's state and registers
   logic [31:0]     level_mem [STORE_DEPTH];
   logic [7:0]      unset_mem [STORE_DEPTH];
   logic [7:0]      scroll_reg;
   logic            ghost_reg;
   int unsigned     fetch_bank;
   int unsigned     fetch_offset;
   int unsigned     scan_row;
   int unsigned     scan_col;
   scan_result_type scan_results_q [$];
   int              fail_n = 0;
   int              pending_n = 0;

   assign mismatches  = fail_n;
   assign outstanding = pending_n;

   // Work out the result of one item and advance the shadow state
   task automatic predict_item(input logic kind, input logic [7:0] pixels);
      scan_result_type r;
      int unsigned     v, idx, step, prev, lvl, b, o;
      int              i;
      logic [31:0]     word;
      r = '0;
      if (kind == KIND_START) begin
         v = scroll_reg;
         if (v >= START_BIAS) v -= START_BIAS;
         fetch_bank   = (v >> 6) & 3;
         fetch_offset = ((v & 'h3f) * 2) & 'h7f;
         scan_row     = 0;
         scan_col     = 0;
      end else begin
         idx  = scan_row * ROW_BYTES + scan_col;
         step = ghost_reg ? 1 : GHOST_LEVELS;
         word = '0;
         // Pixel bit i owns nibble i, so bit 7 lands in the top nibble
         for (i = 0; i < PIX; i++) begin
            prev = level_mem[idx][i*LVL_W +: LVL_W];
            if (unset_mem[idx][i]) begin
               prev      = 0;
               r.changed = 1'b1;
            end
            if (pixels[i])
               lvl = (prev + step > GHOST_LEVELS) ? GHOST_LEVELS : prev + step;
            else
               lvl = (prev < step) ? 0 : prev - step;
            if (lvl != prev) r.changed = 1'b1;
            word[i*LVL_W +: LVL_W] = LVL_W'(lvl);
         end
         level_mem[idx] = word;
         unset_mem[idx] = '0;
         r.levels = word;
         r.row    = 5'(scan_row);
         r.col    = 3'(scan_col);
         r.last   = (scan_row == FRAME_ROWS - 1) && (scan_col == ROW_BYTES - 1);
         // Fetch address walk: skip, bank rollover, short last bank
         b = fetch_bank;
         o = fetch_offset + 1;
         if ((o & 'hf) >= SKIP_AT) o += SKIP_LEN;
         if (o >= BANK_SPAN) begin
            b++;
            o -= BANK_SPAN;
         end
         if (b == LAST_BANK && o >= LAST_BANK_W) begin
            b = 0;
            o -= LAST_BANK_W;
         end
         fetch_bank   = b & 3;
         fetch_offset = o & 'h7f;
         // Scan position wraps to row 0 past the frame end
         if (scan_col == ROW_BYTES - 1) begin
            scan_col = 0;
            scan_row = (scan_row + 1) % FRAME_ROWS;
         end else begin
            scan_col++;
         end
      end
      r.bank   = 2'(fetch_bank);
      r.offset = 7'(fetch_offset);
      scan_results_q.push_back(r);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         fail_n++;
      end
   endtask

   // Watch both channels and the register port
   always @(posedge clock) begin
      scan_result_type want;
      if (reset) begin
         for (int k = 0; k < STORE_DEPTH; k++) begin
            level_mem[k] = '0;
            unset_mem[k] = '1;
         end
         scroll_reg   = '0;
         ghost_reg    = 1'b0;
         fetch_bank   = 0;
         fetch_offset = 0;
         scan_row     = 0;
         scan_col     = 0;
         scan_results_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (scan_results_q.size() == 0) begin
               $error("result with no item pending: pixel_levels 0x%0h row %0d",
                      rsp_mon.pixel_levels, rsp_mon.row);
               fail_n++;
            end else begin
               want = scan_results_q.pop_front();
               check_field("pixel_levels", want.levels, rsp_mon.pixel_levels);
               check_field("row", want.row, rsp_mon.row);
               check_field("byte_column", want.col, rsp_mon.byte_column);
               check_field("changed", want.changed, rsp_mon.changed);
               check_field("next_bank", want.bank, rsp_mon.next_bank);
               check_field("next_offset", want.offset, rsp_mon.next_offset);
               check_field("frame_last", want.last, rsp_mon.frame_last);
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_item(req_mon.kind, req_mon.display_byte);
         if (csr_we) begin
            case (csr_index)
               CSR_SCROLL_START: scroll_reg = csr_wdata;
               CSR_GHOSTING_ON:  ghost_reg  = csr_wdata[0];
               default: ;
            endcase
         end
      end
      pending_n <= scan_results_q.size();
   end

endmodule

// ===== bench/tb_lcd_frame_scan_ghosting.sv =====
// Testbench top for the LCD frame scan block: clock, reset, item stimulus, receiver
// stalls, watchdog and verdict. Checking is done by lfsg_checker.
// Depends on lfsg_pkg, lfsg_if, lcd_frame_scan_ghosting and lfsg_checker.
module tb_lcd_frame_scan_ghosting;
   import lfsg_pkg::*;

   localparam int QUIET_LIMIT  = 3000;
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_CYCLES  = 300;

   typedef enum int {
      RX_OPEN,
      RX_MOSTLY,
      RX_SPARSE,
      RX_TOGGLE,
      RX_HOLD
   } stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;
   int         fail_n;
   int         pending_n;
   int         burst_left;
   int         quiet_cycles = 0;
   bit         hold_request = 1'b0;

   lfsg_req_if req ();
   lfsg_rsp_if rsp ();

   lcd_frame_scan_ghosting i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req),
      .rsp_ch    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lfsg_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req),
      .rsp_mon     (rsp),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (fail_n),
      .outstanding (pending_n)
   );

   always #10 clock = ~clock;

   // Offer one item and hold it until accepted; bursts mostly end in random gaps
   task automatic send_item(input kind_type kind, input logic [7:0] pixels);
      int gap;
      req.valid        <= 1'b1;
      req.kind         <= kind;
      req.display_byte <= pixels;
      do @(posedge clock); while (!req.ready);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering and wait until every result is in
   task automatic wait_idle();
      if (req.valid) req.valid <= 1'b0;
      @(posedge clock);
      while (pending_n != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [7:0] scroll, input logic ghost);
      csr_we    <= 1'b1;
      csr_index <= CSR_SCROLL_START;
      csr_wdata <= scroll;
      @(posedge clock);
      csr_index <= CSR_GHOSTING_ON;
      csr_wdata <= {7'b0, ghost};
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Receiver: stall pattern of its own, one long hold when asked
   initial begin : receiver
      stall_mode_type mode;
      int             len;
      int             n;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            mode = RX_HOLD;
            len  = HOLD_CYCLES;
         end else begin
            mode = stall_mode_type'($urandom_range(0, 3));
            len  = $urandom_range(1, 40);
         end
         for (n = 0; n < len; n++) begin
            case (mode)
               RX_OPEN:   rsp.ready <= 1'b1;
               RX_MOSTLY: rsp.ready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
               RX_TOGGLE: rsp.ready <= n[0];
               default:   rsp.ready <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   // Watchdog: too long without any item moving ends the run
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("lcd_frame_scan_ghosting regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int         count;
      int         phase;
      int         shape;
      int         style;
      int         phase_len;
      int         n;
      logic [7:0] scroll;
      logic [7:0] pixels;
      logic       ghost;
      kind_type   kind;

      req.valid        <= 1'b0;
      req.kind         <= KIND_START;
      req.display_byte <= 8'h00;
      csr_we           <= 1'b0;
      csr_index        <= CSR_SCROLL_START;
      csr_wdata        <= 8'h00;
      burst_left = $urandom_range(1, 40);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Data before any start: walk from address zero, every pixel unset
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'h00);
      send_item(KIND_DATA, 8'hA5);
      // Rewind with full jumps: set, already-dark and mixed pixels
      send_item(KIND_START, 8'h00);
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'h5A);
      send_item(KIND_DATA, 8'h00);
      wait_idle();

      // Bias subtracted right at the threshold, single steps
      write_settings(8'h83, 1'b1);
      send_item(KIND_START, 8'hFF);
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'h00);
      send_item(KIND_DATA, 8'h81);
      wait_idle();

      // Largest start: skip near the bank end, then rollover into bank 2
      write_settings(8'hFF, 1'b1);
      send_item(KIND_START, 8'h00);
      send_item(KIND_DATA, 8'h0F);
      send_item(KIND_DATA, 8'hF0);
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'hFF);
      wait_idle();

      // Just below the bias: short last bank wraps to bank 0
      write_settings(8'h82, 1'b0);
      send_item(KIND_START, 8'h00);
      send_item(KIND_DATA, 8'h00);
      send_item(KIND_DATA, 8'hFF);
      send_item(KIND_DATA, 8'h3C);
      send_item(KIND_DATA, 8'hC3);
      wait_idle();

      // Random phases: mostly framed scans, some loose data and stray starts
      count = 0;
      phase = 0;
      while (count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       scroll = 8'h00;
            1:       scroll = 8'hFF;
            2:       scroll = 8'h82 + 8'($urandom_range(0, 1));
            default: scroll = 8'($urandom);
         endcase
         ghost = 1'($urandom_range(0, 1));
         write_settings(scroll, ghost);
         shape = $urandom_range(0, 7);
         style = $urandom_range(0, 2);
         // Second phase: a full frame keeps coming while the receiver holds off
         if (phase == 1) begin
            hold_request = 1'b1;
            shape        = 0;
         end
         if (shape < 6) begin
            send_item(KIND_START, 8'($urandom));
            count++;
            if (shape < 2)
               phase_len = STORE_DEPTH;
            else if (shape < 5)
               phase_len = $urandom_range(1, 48);
            else
               phase_len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 30);
         end else begin
            phase_len = $urandom_range(1, 30);
         end
         for (n = 0; n < phase_len; n++) begin
            case (style)
               1:       pixels = 8'($urandom | $urandom);
               2:       pixels = 8'($urandom & $urandom);
               default: pixels = 8'($urandom);
            endcase
            kind = (shape >= 6 && $urandom_range(0, 9) == 0) ? KIND_START : KIND_DATA;
            send_item(kind, pixels);
            count++;
         end
         wait_idle();
         phase++;
      end

      if (fail_n == 0)
         $display("lcd_frame_scan_ghosting regression: pass");
      else
         $display("lcd_frame_scan_ghosting regression: fail");
      $finish;
   end

endmodule
